// ----- rtl/pfst_pkg.sv -----
// Shared types and constants for the prime filter sorted table.
package pfst_pkg;

  localparam int VAL_BITS = 16;
  localparam int DIV_BITS = VAL_BITS / 2 + 1;
  localparam int SQ_BITS  = 2 * DIV_BITS;
  localparam int REM_BITS = DIV_BITS + 1;
  localparam int BIT_IDX  = $clog2(VAL_BITS);

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_NOT_PRIME = 2'd1,
    ST_FOUND     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_RUN,
    S_RIPPLE,
    S_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_CHK,
    PR_DIV
  } prime_state_t;

  // Token moving down the cell chain: a search or a rippling displaced entry.
  typedef struct packed {
    logic                vld;
    logic                srch;
    logic                req;
    logic                full;
    logic                eq;
    logic [VAL_BITS-1:0] val;
  } token_t;

  // Events a cell raises when a search token meets its sorted place.
  typedef struct packed {
    logic hit;
    logic found;
    logic ins;
  } cell_ev_t;

endpackage

// ----- rtl/pfst_prime.sv -----
// Trial-division primality test, one remainder bit per cycle while dividing.
module pfst_prime (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pfst_pkg::VAL_BITS-1:0] val,
  output logic                         done,
  output logic                         prime
);
  import pfst_pkg::*;

  prime_state_t           state, state_next;
  logic [VAL_BITS-1:0]    v;
  logic [DIV_BITS-1:0]    d;
  logic [SQ_BITS-1:0]     dsq;
  logic [REM_BITS-1:0]    rem;
  logic [BIT_IDX-1:0]     bc;
  logic [REM_BITS-1:0]    r_sh;
  logic [REM_BITS-1:0]    r_new;

  always_comb begin
    r_sh  = {rem[REM_BITS-2:0], v[bc]};
    r_new = (r_sh >= {1'b0, d}) ? r_sh - {1'b0, d} : r_sh;
  end

  always_comb begin
    state_next = state;
    case (state)
      PR_IDLE: if (start) state_next = PR_CHK;
      PR_CHK: begin
        if (v < VAL_BITS'(2) || dsq > SQ_BITS'(v)) state_next = PR_IDLE;
        else state_next = PR_DIV;
      end
      PR_DIV: begin
        if (bc == '0) state_next = (r_new == '0) ? PR_IDLE : PR_CHK;
      end
      default: state_next = PR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PR_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        PR_IDLE: begin
          if (start) begin
            v   <= val;
            d   <= DIV_BITS'(2);
            dsq <= SQ_BITS'(4);
          end
        end
        PR_CHK: begin
          rem <= '0;
          bc  <= BIT_IDX'(VAL_BITS - 1);
          if (v < VAL_BITS'(2)) begin
            done  <= 1'b1;
            prime <= 1'b0;
          end else if (dsq > SQ_BITS'(v)) begin
            done  <= 1'b1;
            prime <= 1'b1;
          end
        end
        PR_DIV: begin
          rem <= r_new;
          bc  <= bc - 1'b1;
          if (bc == '0) begin
            if (r_new == '0) begin
              done  <= 1'b1;
              prime <= 1'b0;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              dsq <= dsq + SQ_BITS'({d, 1'b1});
              d   <= d + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pfst_cell.sv -----
// One table entry of the sorted chain: compare, insert, pass displaced entry on.
module pfst_cell #(
  parameter int VW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pfst_pkg::token_t  tin,
  output pfst_pkg::token_t  tout,
  output pfst_pkg::cell_ev_t ev
);
  import pfst_pkg::*;

  logic [VW-1:0] stored;
  logic          valid;
  logic          le;
  token_t        tout_next;

  always_comb begin
    le        = valid && (VAL_BITS'(stored) <= tin.val);
    ev        = '0;
    tout_next = '0;
    if (tin.vld && tin.srch) begin
      if (le) begin
        tout_next    = tin;
        tout_next.eq = (VAL_BITS'(stored) == tin.val);
      end else begin
        ev.hit   = 1'b1;
        ev.found = tin.req && tin.eq;
        ev.ins   = !(tin.req && tin.eq) && !tin.full;
        if (ev.ins && valid) begin
          tout_next.vld = 1'b1;
          tout_next.val = VAL_BITS'(stored);
        end
      end
    end else if (tin.vld && valid) begin
      tout_next.vld = 1'b1;
      tout_next.val = VAL_BITS'(stored);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tout_next.vld;
      if (ev.ins || (tin.vld && !tin.srch)) begin
        stored <= VW'(tin.val);
        valid  <= 1'b1;
      end
    end
    tout.srch <= tout_next.srch;
    tout.req  <= tout_next.req;
    tout.full <= tout_next.full;
    tout.eq   <= tout_next.eq;
    tout.val  <= tout_next.val;
  end

endmodule

// ----- rtl/prime_filter_sorted_table_unit.sv -----
// Top level: prime filter and sorted table built as a chain of entry cells.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid/in_stall, req_type,value| into block
//  out     | out_valid/out_stall, status,     | out of block
//          | position, entry_count            |
//
// A query passes a search token down the cell chain to its sorted place; an
// insert also waits for the shifted tail to settle. A load first runs trial
// division, one divisor after another, and goes on only for a prime value.
// Reset clears the count and the cell occupancy; no clearing pass is needed.
// A stalled result stays on the outputs while the next item is taken.
module prime_filter_sorted_table_unit #(
  parameter int TABLE_DEPTH = 128,
  parameter int VALUE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  position,
  output logic [7:0]  entry_count
);
  import pfst_pkg::*;

  localparam int VW = (VALUE_BITS < VAL_BITS) ? VALUE_BITS : VAL_BITS;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctrl_state_t         state, state_next;
  logic                req_r;
  logic [VAL_BITS-1:0] val_r;
  logic [CW-1:0]       idx, cnt, cnt_new;
  status_t             res_status;
  logic [CW-1:0]       res_pos;
  logic                accept, p_done, p_prime;
  logic                any_hit, any_found, any_ins;

  token_t   tok [0:TABLE_DEPTH];
  cell_ev_t ev  [0:TABLE_DEPTH-1];
  logic [TABLE_DEPTH-1:0] hit_v, fnd_v, ins_v;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  pfst_prime u_prime (
    .clk   (clk),
    .rst   (rst),
    .start (accept && !req_type),
    .val   (VAL_BITS'(value[VW-1:0])),
    .done  (p_done),
    .prime (p_prime)
  );

  always_comb begin
    tok[0]      = '0;
    tok[0].vld  = (state == S_RUN) && (idx == '0);
    tok[0].srch = 1'b1;
    tok[0].req  = req_r;
    tok[0].full = (cnt == CW'(TABLE_DEPTH));
    tok[0].val  = val_r;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    pfst_cell #(.VW(VW)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .tin  (tok[k]),
      .tout (tok[k+1]),
      .ev   (ev[k])
    );
    assign hit_v[k] = ev[k].hit;
    assign fnd_v[k] = ev[k].found;
    assign ins_v[k] = ev[k].ins;
  end

  assign any_hit   = |hit_v;
  assign any_found = |fnd_v;
  assign any_ins   = |ins_v;
  assign cnt_new   = (res_status == ST_INSERTED) ? cnt + 1'b1 : cnt;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = req_type ? S_RUN : S_PRIME;
      S_PRIME:  if (p_done) state_next = p_prime ? S_RUN : S_FIN;
      S_RUN: begin
        if (any_hit) state_next = (any_ins && idx != cnt) ? S_RIPPLE : S_FIN;
        else if (tok[TABLE_DEPTH].vld) state_next = S_FIN;
      end
      S_RIPPLE: if (idx == cnt) state_next = S_FIN;
      S_FIN:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_r <= req_type;
            val_r <= VAL_BITS'(value[VW-1:0]);
            idx   <= '0;
          end
        end
        S_PRIME: begin
          if (p_done && !p_prime) begin
            res_status <= ST_NOT_PRIME;
            res_pos    <= '0;
          end
        end
        S_RUN: begin
          idx <= idx + 1'b1;
          if (any_hit) begin
            res_pos <= idx;
            if (any_found) begin
              res_status <= ST_FOUND;
              res_pos    <= idx - 1'b1;
            end else if (any_ins) begin
              res_status <= ST_INSERTED;
            end else begin
              res_status <= ST_FULL;
              res_pos    <= '0;
            end
          end else if (tok[TABLE_DEPTH].vld) begin
            // search ran off the end: every entry is <= the value
            if (tok[TABLE_DEPTH].req && tok[TABLE_DEPTH].eq) begin
              res_status <= ST_FOUND;
              res_pos    <= CW'(TABLE_DEPTH - 1);
            end else begin
              res_status <= ST_FULL;
              res_pos    <= '0;
            end
          end
        end
        S_RIPPLE: idx <= idx + 1'b1;
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            position    <= 7'(res_pos);
            entry_count <= 8'(cnt_new);
            cnt         <= cnt_new;
          end
        end
        default: ;
      endcase
    end
  end

  a_one_place: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_v))
    else $error("more than one cell claimed the sorted place");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");
  a_ripple_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_RIPPLE |-> idx <= cnt)
    else $error("ripple ran past the last occupied entry");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || !out_stall)) |=> out_valid && state == S_IDLE)
    else $error("finished item not presented");
  a_no_tail_ripple: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_DEPTH].vld |-> tok[TABLE_DEPTH].srch)
    else $error("displaced entry fell off the end of the chain");

endmodule

// ----- tb/tb_prime_filter_sorted_table_unit.sv -----
// Testbench for the prime filter sorted table: directed and random items, scoreboard check.
`timescale 1ns / 1ps

module tb_prime_filter_sorted_table_unit;
  import pfst_pkg::*;

  localparam int DEPTH = 128;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam bit REQ_LOAD = 1'b0;
  localparam bit REQ_QUERY = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [15:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [6:0] position;
  logic [7:0] entry_count;

  typedef struct packed {
    status_t    st;
    logic [6:0] pos;
    logic [7:0] cnt;
  } table_result_t;

  table_result_t pending_results[$];
  logic [15:0] model_table[DEPTH];
  int unsigned model_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit done = 1'b0;

  prime_filter_sorted_table_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit value_is_prime(input logic [15:0] v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++)
      if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Compute the expected result and update the shadow table.
  function automatic table_result_t apply_item(input bit req, input logic [15:0] v);
    table_result_t r;
    int unsigned at;
    r.st = ST_INSERTED;
    r.pos = '0;
    if (req == REQ_LOAD && !value_is_prime(v)) begin
      r.st = ST_NOT_PRIME;
    end else begin
      at = 0;
      while (at < model_count && model_table[at] <= v) at++;
      if (req == REQ_QUERY && at > 0 && model_table[at-1] == v) begin
        r.st = ST_FOUND;
        r.pos = 7'(at - 1);
      end else if (model_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        for (int k = model_count; k > at; k--) model_table[k] = model_table[k-1];
        model_table[at] = v;
        model_count++;
        r.pos = 7'(at);
      end
    end
    r.cnt = 8'(model_count);
    return r;
  endfunction

  task automatic send_item(input bit req, input logic [15:0] v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    value <= v;
    pending_results.push_back(apply_item(req, v));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    // the block stalls its input after every item, so this gap costs nothing
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d pos=%0d cnt=%0d",
                                       status, position, entry_count);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.st || position !== exp_r.pos || entry_count !== exp_r.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pos=%0d cnt=%0d got st=%0d pos=%0d cnt=%0d",
                     exp_r.st, exp_r.pos, exp_r.cnt, status, position, entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("prime_filter_sorted_table_unit test failed");
      $finish;
    end
  end

  task automatic test_directed;
    send_item(REQ_LOAD, 16'd0);
    send_item(REQ_LOAD, 16'd1);
    send_item(REQ_LOAD, 16'd2);
    send_item(REQ_LOAD, 16'd3);
    send_item(REQ_LOAD, 16'd4);
    send_item(REQ_LOAD, 16'd65521);   // largest 16-bit prime
    send_item(REQ_LOAD, 16'd65535);
    send_item(REQ_LOAD, 16'd65025);   // square of 255, not prime
    send_item(REQ_LOAD, 16'd3);       // duplicate prime
    send_item(REQ_QUERY, 16'd3);      // found among duplicates
    send_item(REQ_QUERY, 16'd0);
    send_item(REQ_QUERY, 16'd65535);
    send_item(REQ_QUERY, 16'd65535);
    send_item(REQ_QUERY, 16'd100);
    send_item(REQ_QUERY, 16'hAAAA);
    send_item(REQ_QUERY, 16'h5555);
    drain();
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    logic [15:0] v;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      if (model_count > 0 && $urandom_range(2) == 0)
        v = model_table[$urandom_range(model_count - 1)];
      else if ($urandom_range(1)) v = 16'($urandom_range(300));
      else v = 16'($urandom);
      send_item(1'($urandom_range(1)), v);
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_item(REQ_QUERY, 16'($urandom_range(500)));
    join
    drain();
  endtask

  // Fill to capacity, then exercise full-table behavior.
  task automatic test_full;
    while (model_count < DEPTH) send_item(REQ_QUERY, 16'($urandom));
    send_item(REQ_QUERY, model_table[0]);
    send_item(REQ_QUERY, model_table[DEPTH-1]);
    send_item(REQ_LOAD, 16'd8);
    send_item(REQ_LOAD, 16'd7);
    for (int i = 0; i < 60; i++)
      send_item(1'($urandom_range(1)),
                $urandom_range(1) ? model_table[$urandom_range(DEPTH-1)] : 16'($urandom));
    drain();
  endtask

  initial begin
    model_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(30, 0, 0);
    test_backpressure();
    test_random(20, 69, 0);
    test_random(20, 0, 69);
    test_full();            // leaves table full; later inserts hit full paths
    test_random(200, 36, 36);
    test_random(100, 0, 0);
    test_random(150, 69, 0);
    test_random(150, 0, 69);
    done = 1'b1;
    if (mismatches == 0 && pending_results.size() == 0)
      $display("prime_filter_sorted_table_unit test passed");
    else
      $display("prime_filter_sorted_table_unit test failed");
    $finish;
  end

endmodule
